// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/whdmc_pkg.sv =====
package whdmc_pkg;

    localparam int SLOTS       = 256;
    localparam int MAX_WORD    = 128;
    localparam int MIN_LETTERS = 3;
    localparam int MAX_LETTER  = 122;

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int POS_W    = $clog2(MAX_WORD);
    localparam int LEN_W    = $clog2(MAX_WORD + 1);
    localparam int SIZE_W   = 9;
    localparam int SUM_W    = $clog2(MAX_WORD * MAX_LETTER + 1);
    localparam int DIVCNT_W = $clog2(SUM_W);
    localparam int WADDR_W  = SLOT_W + POS_W;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(SLOTS);

    typedef logic [1:0] t_command;
    localparam t_command CMD_TEXT  = 2'd0;
    localparam t_command CMD_FLUSH = 2'd1;
    localparam t_command CMD_READ  = 2'd2;

    localparam logic KIND_PLACE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_PLACE,
        ST_COPY
    } t_state;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
    endfunction

    // Zero behaves as one slot, anything above the table depth as the full table.
    function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] ts);
        logic [SIZE_W-1:0] r;
        if (ts == '0) begin
            r = SIZE_W'(1);
        end else if (ts > SIZE_W'(SLOTS)) begin
            r = SIZE_W'(SLOTS);
        end else begin
            r = ts;
        end
        return r;
    endfunction

endpackage

// ===== rtl/word_hash_direct_mapped_cache_unit.sv =====
// Word hash cache: text bytes stream in one transaction at a time and letters are
// buffered until whitespace or an end-of-text command closes the word; a word of
// three or more letters is stored in slot (letter sum mod table size), replacing
// that slot's old word, and one placed result reports the slot and whether a word
// was replaced. A text byte that closes no stored word leaves the block ready for
// the next transaction. A read command is accepted, then waits in the read state
// for the output register. A closing word is accepted, passes through the
// bit-serial remainder unit, waits for the output register to place the result,
// and then has its letters copied from the word buffer into the slot memory over
// its single write port, one letter a cycle. The block takes no new transaction
// while a read or a word store is in progress. Slot occupancy clears at reset;
// there is no clearing pass.
module word_hash_direct_mapped_cache_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [8:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_text_byte,
    input  logic [7:0] i_read_slot,
    input  logic [6:0] i_read_position,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_result_kind,
    output logic [7:0] o_placed_slot,
    output logic       o_replaced,
    output logic [7:0] o_read_data
);

    localparam int SLOT_W   = whdmc_pkg::SLOT_W;
    localparam int POS_W    = whdmc_pkg::POS_W;
    localparam int LEN_W    = whdmc_pkg::LEN_W;
    localparam int SIZE_W   = whdmc_pkg::SIZE_W;
    localparam int SUM_W    = whdmc_pkg::SUM_W;
    localparam int DIVCNT_W = whdmc_pkg::DIVCNT_W;
    localparam int WADDR_W  = whdmc_pkg::WADDR_W;

    whdmc_pkg::t_state r_state, n_state;

    logic [SIZE_W-1:0] r_table_size;

    // Word buffer and the letter count / sum of the word being collected.
    logic [7:0]       pend_mem [whdmc_pkg::MAX_WORD];
    logic [7:0]       r_pend_q;
    logic [LEN_W-1:0] r_len;
    logic [SUM_W-1:0] r_sum;

    // Slot storage.
    logic [7:0]              word_mem [whdmc_pkg::SLOTS * whdmc_pkg::MAX_WORD];
    logic [7:0]              r_word_q;
    logic [LEN_W-1:0]        len_mem [whdmc_pkg::SLOTS];
    logic [LEN_W-1:0]        r_len_q;
    logic [whdmc_pkg::SLOTS-1:0] r_slot_used;
    logic                    r_rd_used;
    logic [POS_W-1:0]        r_rd_pos;

    // Remainder unit.
    logic [SUM_W-1:0]    r_dividend;
    logic [SIZE_W-1:0]   r_divisor;
    logic [SLOT_W-1:0]   r_rem;
    logic [DIVCNT_W-1:0] r_div_cnt;
    logic [SIZE_W-1:0]   div_trial;
    logic [SIZE_W-1:0]   div_next;

    // Copy sequencer.
    logic [LEN_W-1:0] r_cp_len;
    logic [LEN_W-1:0] r_cp_idx;
    logic             r_cp_wr_en;
    logic [POS_W-1:0] r_cp_wr_idx;

    // Output register.
    logic             r_out_valid;
    logic             r_out_kind;
    logic [SLOT_W-1:0] r_out_slot;
    logic             r_out_replaced;
    logic [7:0]       r_out_data;

    logic in_fire;
    logic out_free;
    logic is_end;
    logic is_add;
    logic is_rd;
    logic start_word;
    logic cp_issue;
    logic cp_done;
    logic load_place;
    logic load_read;
    logic [7:0] rd_data;

    assign o_in_ready = (r_state == whdmc_pkg::ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign is_end = ((i_command == whdmc_pkg::CMD_TEXT) && whdmc_pkg::is_space(i_text_byte))
                    || (i_command == whdmc_pkg::CMD_FLUSH);
    assign is_add = (i_command == whdmc_pkg::CMD_TEXT) && whdmc_pkg::is_letter(i_text_byte)
                    && (r_len < LEN_W'(whdmc_pkg::MAX_WORD));
    assign is_rd  = (i_command == whdmc_pkg::CMD_READ);
    assign start_word = in_fire && is_end && (r_len >= LEN_W'(whdmc_pkg::MIN_LETTERS));

    // One restoring step per cycle; the remainder always stays below the divisor.
    assign div_trial = {r_rem, r_dividend[SUM_W-1]};
    assign div_next  = (div_trial >= r_divisor) ? (div_trial - r_divisor) : div_trial;

    assign cp_issue = (r_state == whdmc_pkg::ST_COPY) && (r_cp_idx < r_cp_len);
    assign cp_done  = (r_state == whdmc_pkg::ST_COPY) && !cp_issue && !r_cp_wr_en;

    assign rd_data = (r_rd_used && ({1'b0, r_rd_pos} < r_len_q)) ? r_word_q : 8'd0;

    always_comb begin
        n_state    = r_state;
        load_place = 1'b0;
        load_read  = 1'b0;
        unique case (r_state)
            whdmc_pkg::ST_IDLE: begin
                if (in_fire && is_rd) begin
                    n_state = whdmc_pkg::ST_READ;
                end else if (start_word) begin
                    n_state = whdmc_pkg::ST_DIV;
                end
            end
            whdmc_pkg::ST_READ: begin
                if (out_free) begin
                    load_read = 1'b1;
                    n_state   = whdmc_pkg::ST_IDLE;
                end
            end
            whdmc_pkg::ST_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = whdmc_pkg::ST_PLACE;
                end
            end
            whdmc_pkg::ST_PLACE: begin
                if (out_free) begin
                    load_place = 1'b1;
                    n_state    = whdmc_pkg::ST_COPY;
                end
            end
            whdmc_pkg::ST_COPY: begin
                if (cp_done) begin
                    n_state = whdmc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = whdmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= whdmc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= whdmc_pkg::TABLE_SIZE_RESET;
            r_len        <= '0;
            r_sum        <= '0;
            r_slot_used  <= '0;
            r_out_valid  <= 1'b0;
            r_cp_wr_en   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_table_size <= i_cfg_wr_data;
            end
            if (in_fire && is_end) begin
                r_len <= '0;
                r_sum <= '0;
            end else if (in_fire && is_add) begin
                r_len <= r_len + LEN_W'(1);
                r_sum <= r_sum + SUM_W'(i_text_byte);
            end
            if (load_place) begin
                r_slot_used[r_rem] <= 1'b1;
            end
            if (load_place || load_read) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_cp_wr_en <= cp_issue;
        end
    end

    // Remainder unit and copy sequencer data path.
    always_ff @(posedge i_clk) begin
        if (start_word) begin
            r_dividend <= r_sum;
            r_divisor  <= whdmc_pkg::effective_size(r_table_size);
            r_rem      <= '0;
            r_div_cnt  <= DIVCNT_W'(SUM_W - 1);
            r_cp_len   <= r_len;
            r_cp_idx   <= '0;
        end else if (r_state == whdmc_pkg::ST_DIV) begin
            r_dividend <= {r_dividend[SUM_W-2:0], 1'b0};
            r_rem      <= div_next[SLOT_W-1:0];
            r_div_cnt  <= r_div_cnt - DIVCNT_W'(1);
        end else if (cp_issue) begin
            r_cp_idx <= r_cp_idx + LEN_W'(1);
        end
        if (cp_issue) begin
            r_cp_wr_idx <= r_cp_idx[POS_W-1:0];
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load_place) begin
            r_out_kind     <= whdmc_pkg::KIND_PLACE;
            r_out_slot     <= r_rem;
            r_out_replaced <= r_slot_used[r_rem];
            r_out_data     <= 8'd0;
        end else if (load_read) begin
            r_out_kind     <= whdmc_pkg::KIND_READ;
            r_out_slot     <= '0;
            r_out_replaced <= 1'b0;
            r_out_data     <= rd_data;
        end
    end

    // Word buffer memory.
    always_ff @(posedge i_clk) begin
        if (in_fire && is_add) begin
            pend_mem[r_len[POS_W-1:0]] <= i_text_byte;
        end
        if (cp_issue) begin
            r_pend_q <= pend_mem[r_cp_idx[POS_W-1:0]];
        end
    end

    // Slot character memory: the copy writes, a read transaction reads.
    always_ff @(posedge i_clk) begin
        if (r_cp_wr_en) begin
            word_mem[WADDR_W'({r_rem, r_cp_wr_idx})] <= r_pend_q;
        end
        if (in_fire && is_rd) begin
            r_word_q <= word_mem[WADDR_W'({i_read_slot, i_read_position})];
        end
    end

    // Slot length memory; occupancy bits decide whether a length is meaningful.
    always_ff @(posedge i_clk) begin
        if (load_place) begin
            len_mem[r_rem] <= r_cp_len;
        end
        if (in_fire && is_rd) begin
            r_len_q   <= len_mem[i_read_slot];
            r_rd_used <= r_slot_used[i_read_slot];
            r_rd_pos  <= i_read_position;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_placed_slot = r_out_slot;
    assign o_replaced    = r_out_replaced;
    assign o_read_data   = r_out_data;

endmodule

// ===== rtl/whdmc_checker.sv =====
`include "assert_macros.svh"

module whdmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_command,
    input logic [7:0] i_text_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_result_kind,
    input logic [7:0] o_placed_slot,
    input logic       o_replaced,
    input logic [7:0] o_read_data
);

    logic in_fire;
    logic letter;
    logic rd_fire;
    logic letter_fire;
    logic rd_shown;
    logic place_shown;

    assign in_fire = i_in_valid && o_in_ready;
    assign letter  = ((i_text_byte >= 8'd65) && (i_text_byte <= 8'd90))
                     || ((i_text_byte >= 8'd97) && (i_text_byte <= 8'd122));

    assign rd_fire     = in_fire && (i_command == whdmc_pkg::CMD_READ);
    assign letter_fire = in_fire && (i_command == whdmc_pkg::CMD_TEXT) && letter;
    assign rd_shown    = o_out_valid && (o_result_kind == whdmc_pkg::KIND_READ);
    assign place_shown = o_out_valid && (o_result_kind == whdmc_pkg::KIND_PLACE);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_NEXT(a_read_busy, i_clk, i_rst_n, rd_fire, !o_in_ready)
    `ASSERT_NEXT(a_letter_fast, i_clk, i_rst_n, letter_fire, o_in_ready)
    `ASSERT_NOW(a_read_clean, i_clk, i_rst_n, rd_shown, (o_placed_slot == 8'd0) && !o_replaced)
    `ASSERT_NOW(a_place_clean, i_clk, i_rst_n, place_shown, o_read_data == 8'd0)

endmodule

bind word_hash_direct_mapped_cache_unit whdmc_checker u_whdmc_checker (.*);
